[sv/kcgd_pkg.sv]
// Shared types and constants for the key click gesture detector.
// No dependencies; imported by the lane, the merge stage and the top level.
`default_nettype none

package kcgd_pkg;

  // Event codes reported per key and per scan.
  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_CLICK  = 3'd1,
    EV_DOUBLE = 3'd2,
    EV_LONG   = 3'd3,
    EV_HOLD   = 3'd4
  } kcgd_event_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_DEBOUNCE    = 2'd0;
  localparam logic [1:0] CFG_LONG_PRESS  = 2'd1;
  localparam logic [1:0] CFG_HOLD_REPEAT = 2'd2;
  localparam logic [1:0] CFG_DBL_WINDOW  = 2'd3;

  localparam logic [15:0] DEBOUNCE_RST    = 16'd20;
  localparam logic [15:0] LONG_PRESS_RST  = 16'd1000;
  localparam logic [15:0] HOLD_REPEAT_RST = 16'd2000;
  localparam logic [15:0] DBL_WINDOW_RST  = 16'd300;

  // Thresholds shared by all key lanes, in milliseconds.
  typedef struct packed {
    logic [15:0] debounce;
    logic [15:0] long_press;
    logic [15:0] hold_repeat;
    logic [15:0] dbl_window;
  } kcgd_cfg_t;

endpackage

`default_nettype wire

[sv/kcgd_lane.sv]
// One key's gesture state machine: phase, press mark time and first-click flag.
// Depends on kcgd_pkg for the event codes and the threshold struct.
`default_nettype none

module kcgd_lane (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               upd,
  input  wire logic [31:0]        now_ms,
  input  wire logic               down,
  input  wire kcgd_pkg::kcgd_cfg_t cfg,
  output kcgd_pkg::kcgd_event_t   ev
);
  import kcgd_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'b0001,
    PH_PRESSED = 4'b0010,
    PH_LONG    = 4'b0100,
    PH_WAIT    = 4'b1000
  } kcgd_phase_t;

  kcgd_phase_t phase_r, phase_nxt;
  logic [31:0] mark_r, mark_nxt;
  logic        first_r, first_nxt;
  logic [31:0] elapsed;

  // Elapsed time wraps modulo 2^32; a 16-bit threshold is reached when the
  // upper half is nonzero or the lower half compares high enough.
  function automatic logic reached(input logic [31:0] el, input logic [15:0] thr);
    reached = (el[31:16] != 16'd0) || (el[15:0] >= thr);
  endfunction

  assign elapsed = now_ms - mark_r;

  always_comb begin
    phase_nxt = phase_r;
    mark_nxt  = mark_r;
    first_nxt = first_r;
    ev        = EV_NONE;
    case (phase_r)
      PH_IDLE: begin
        if (down) begin
          phase_nxt = PH_PRESSED;
          mark_nxt  = now_ms;
          first_nxt = 1'b0;
        end
      end
      PH_PRESSED: begin
        if (!down) begin
          if (reached(elapsed, cfg.debounce)) begin
            if (!first_r) begin
              phase_nxt = PH_WAIT;
              mark_nxt  = now_ms;
              first_nxt = 1'b1;
            end else begin
              phase_nxt = PH_IDLE;
              first_nxt = 1'b0;
              ev        = EV_DOUBLE;
            end
          end else begin
            // A press that is too short drops any pending click silently.
            phase_nxt = PH_IDLE;
          end
        end else if (reached(elapsed, cfg.long_press)) begin
          phase_nxt = PH_LONG;
        end
      end
      PH_LONG: begin
        if (!down) begin
          phase_nxt = PH_IDLE;
          first_nxt = 1'b0;
          ev        = EV_LONG;
        end else if (reached(elapsed, cfg.hold_repeat)) begin
          mark_nxt = now_ms;
          ev       = EV_HOLD;
        end
      end
      PH_WAIT: begin
        if (down) begin
          phase_nxt = PH_PRESSED;
          mark_nxt  = now_ms;
        end else if (reached(elapsed, cfg.dbl_window)) begin
          phase_nxt = PH_IDLE;
          first_nxt = 1'b0;
          ev        = EV_CLICK;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      mark_r  <= 32'd0;
      first_r <= 1'b0;
    end else if (upd) begin
      phase_r <= phase_nxt;
      mark_r  <= mark_nxt;
      first_r <= first_nxt;
    end
  end

endmodule

`default_nettype wire

[sv/kcgd_merge.sv]
// Merge stage: captures the events of all key lanes for one scan and hands
// them out one key per transaction through an output register. Uses kcgd_pkg.
`default_nettype none

module kcgd_merge #(
  parameter int NUM_KEYS = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire kcgd_pkg::kcgd_event_t lane_ev [NUM_KEYS],
  output logic                       cap,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [1:0]                 out_key_index,
  output logic [2:0]                 out_event_code,
  output logic                       out_last_key
);
  import kcgd_pkg::*;

  localparam int KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int CW = $clog2(NUM_KEYS + 1);

  kcgd_event_t   codes_r [NUM_KEYS];
  kcgd_event_t   codes_nxt [NUM_KEYS];
  logic [CW-1:0] rem_r, rem_nxt;
  logic [KW-1:0] kidx_r, kidx_nxt;
  logic          mv;
  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_key_r;
  kcgd_event_t   out_ev_r;
  logic          out_last_r;

  // An entry moves to the output register whenever that register is free or
  // being emptied; the buffer accepts a new scan as its final entry leaves.
  assign mv       = (rem_r != CW'(0)) && (!out_valid_r || !out_stall);
  assign in_stall = !((rem_r == CW'(0)) || ((rem_r == CW'(1)) && mv));
  assign cap      = in_valid && !in_stall;

  always_comb begin
    codes_nxt = codes_r;
    rem_nxt   = rem_r;
    kidx_nxt  = kidx_r;
    if (mv) begin
      for (int i = 0; i < NUM_KEYS - 1; i++) begin
        codes_nxt[i] = codes_r[i + 1];
      end
      codes_nxt[NUM_KEYS - 1] = EV_NONE;
      rem_nxt  = rem_r - CW'(1);
      kidx_nxt = kidx_r + KW'(1);
    end
    if (cap) begin
      codes_nxt = lane_ev;
      rem_nxt   = CW'(NUM_KEYS);
      kidx_nxt  = KW'(0);
    end
  end

  always_comb begin
    if (mv) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r       <= CW'(0);
      kidx_r      <= KW'(0);
      out_valid_r <= 1'b0;
    end else begin
      rem_r       <= rem_nxt;
      kidx_r      <= kidx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    codes_r <= codes_nxt;
    if (mv) begin
      out_key_r  <= 2'(kidx_r);
      out_ev_r   <= codes_r[0];
      out_last_r <= (kidx_r == KW'(NUM_KEYS - 1));
    end
  end

  assign out_valid      = out_valid_r;
  assign out_key_index  = out_key_r;
  assign out_event_code = out_ev_r;
  assign out_last_key   = out_last_r;

`ifndef ASSERT_OFF
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(rem_r) <= NUM_KEYS)
    else $error("merge buffer count exceeds key count");

  a_cap_fill: assert property (@(posedge clk) disable iff (!rst_n)
    cap |=> (rem_r == CW'(NUM_KEYS)) && (kidx_r == KW'(0)))
    else $error("scan capture did not fill the merge buffer");

  a_idx_track: assert property (@(posedge clk) disable iff (!rst_n)
    (rem_r != CW'(0)) |-> (32'(kidx_r) + 32'(rem_r) == NUM_KEYS))
    else $error("key index and remaining count out of step");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (mv && (rem_r == CW'(1)) && !cap) |=> (rem_r == CW'(0)))
    else $error("merge buffer did not drain after its final entry");

  a_move_out: assert property (@(posedge clk) disable iff (!rst_n)
    mv |=> out_valid_r)
    else $error("moved entry did not reach the output register");
`endif

endmodule

`default_nettype wire

[sv/key_click_gesture_detector_top.sv]
// Key click gesture detector. Each input transaction is one scan: a
// millisecond timestamp and the pressed level of every key. One lane per key
// runs that key's click, double-click, long-press and hold machine, and all
// lanes update together in the cycle the scan is accepted. The merge stage
// then delivers NUM_KEYS result transactions in key order, one per clock
// while out_stall stays low, the final one flagged by out_last_key. The
// single result port limits the scan rate; a new scan is taken in the
// cycle the previous scan's last result enters the output register, so
// results stream without gaps while out_stall is low. Thresholds are written
// through cfg_we/cfg_index/cfg_wdata; the user must write them only while
// the block is idle, which it does not enforce. Keys beyond the fourth
// never see a press, and out_key_index carries the key number modulo four.
`default_nettype none

module key_click_gesture_detector_top #(
  parameter int NUM_KEYS = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_now_ms,
  input  wire logic [3:0]  in_pressed_mask,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_key_index,
  output logic [2:0]       out_event_code,
  output logic             out_last_key,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);
  import kcgd_pkg::*;

  kcgd_cfg_t   cfg_r, cfg_nxt;
  kcgd_event_t lane_ev [NUM_KEYS];
  logic        cap;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_DEBOUNCE:    cfg_nxt.debounce    = cfg_wdata;
        CFG_LONG_PRESS:  cfg_nxt.long_press  = cfg_wdata;
        CFG_HOLD_REPEAT: cfg_nxt.hold_repeat = cfg_wdata;
        CFG_DBL_WINDOW:  cfg_nxt.dbl_window  = cfg_wdata;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce    <= DEBOUNCE_RST;
      cfg_r.long_press  <= LONG_PRESS_RST;
      cfg_r.hold_repeat <= HOLD_REPEAT_RST;
      cfg_r.dbl_window  <= DBL_WINDOW_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    logic down;
    if (k < 4) begin : g_mask
      assign down = in_pressed_mask[k];
    end else begin : g_none
      assign down = 1'b0;
    end

    kcgd_lane u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .upd    (cap),
      .now_ms (in_now_ms),
      .down   (down),
      .cfg    (cfg_r),
      .ev     (lane_ev[k])
    );
  end

  kcgd_merge #(
    .NUM_KEYS (NUM_KEYS)
  ) u_merge (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .lane_ev        (lane_ev),
    .cap            (cap),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_key_index  (out_key_index),
    .out_event_code (out_event_code),
    .out_last_key   (out_last_key)
  );

endmodule

`default_nettype wire
